/* sv/erm_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Euler rotation matrix package
// Field types, fixed-point widths, CORDIC constants and rounding helpers.
// ---------------------------------------------------------------------------
package erm_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int FRAC_BITS     = 14;
   localparam int VAL_BITS      = FRAC_BITS + 2;
   localparam int AXES          = 3;

   // CORDIC datapath: fraction bits, word width, iterations
   localparam int CORDIC_FRAC   = FRAC_BITS + 26;
   localparam int CORDIC_BITS   = CORDIC_FRAC + 3;
   localparam int CORDIC_STAGES = FRAC_BITS + 24;
   localparam int ANGLE_SHIFT   = CORDIC_FRAC - ANGLE_BITS + 3;
   localparam int DROP_BITS     = CORDIC_FRAC - FRAC_BITS;

   // radians to binary angle units with ANGLE_SHIFT extra fraction bits
   localparam real ATAN_SCALE   = (2.0 ** (ANGLE_BITS - 1 + ANGLE_SHIFT))
                                  / 3.14159265358979323846;

   typedef logic signed [CORDIC_BITS-1:0] cordic_word_type;
   typedef logic [CORDIC_STAGES-1:0][CORDIC_BITS-1:0] atan_table_type;
   typedef logic signed [VAL_BITS-1:0] val_type;
   typedef logic signed [2*VAL_BITS-1:0] prod_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle_x;
      logic [ANGLE_BITS-1:0] angle_y;
      logic [ANGLE_BITS-1:0] angle_z;
   } req_payload_type;

   typedef struct packed {
      val_type m00;
      val_type m01;
      val_type m02;
      val_type m10;
      val_type m11;
      val_type m12;
      val_type m20;
      val_type m21;
      val_type m22;
   } rsp_payload_type;

   localparam val_type  VAL_ONE  = val_type'(1) <<< FRAC_BITS;
   localparam prod_type PROD_HALF = prod_type'(1) <<< (FRAC_BITS - 1);

   // atan(2^-i) in binary angle units with ANGLE_SHIFT extra fraction bits
   function automatic atan_table_type atan_table();
      atan_table_type tbl;
      real            a;
      tbl = '0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         a = $atan(2.0 ** (-i)) * ATAN_SCALE;
         tbl[i] = CORDIC_BITS'(longint'(a));
      end
      return tbl;
   endfunction

   // total CORDIC magnitude growth over all stages
   function automatic real cordic_stretch();
      real k;
      k = 1.0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         k = k * $sqrt(1.0 + 2.0 ** (-2 * i));
      end
      return k;
   endfunction

   localparam atan_table_type  ATAN_TABLE  = atan_table();
   localparam cordic_word_type CORDIC_GAIN =
      cordic_word_type'(longint'((2.0 ** CORDIC_FRAC) / cordic_stretch()));

   // product rounded to nearest at FRAC_BITS, ties toward plus infinity
   function automatic val_type rnd_mul(input val_type a, input val_type b);
      prod_type p;
      p = a * b;
      p = p + PROD_HALF;
      return VAL_BITS'(p >>> FRAC_BITS);
   endfunction

   function automatic val_type clamp_sum(input val_type a, input val_type b);
      logic signed [VAL_BITS:0] s;
      logic signed [VAL_BITS:0] one;
      one = {VAL_ONE[VAL_BITS-1], VAL_ONE};
      s = {a[VAL_BITS-1], a} + {b[VAL_BITS-1], b};
      if (s > one) begin
         return VAL_ONE;
      end else if (s < -one) begin
         return -VAL_ONE;
      end
      return VAL_BITS'(s);
   endfunction

   function automatic val_type cordic_round(input cordic_word_type v);
      cordic_word_type t;
      t = v + (cordic_word_type'(1) <<< (DROP_BITS - 1));
      return VAL_BITS'(t >>> DROP_BITS);
   endfunction

endpackage
`default_nettype wire

/* sv/euler_rotation_matrix_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Euler rotation matrix unit
// Sine and cosine of three binary angles by pipelined CORDIC, then the
// 3x3 product Z * Y * X in Q1.14 with rounded products.
// ---------------------------------------------------------------------------
// The CORDIC iteration stages, one per register stage, are followed by the
// sine/cosine, first product, second product and output registers.
// Throughput: one transfer per cycle; the whole pipeline holds while the
// output register is stalled.
// Reset clears all valid bits; payload registers are not reset.
module euler_rotation_matrix_unit import erm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_type;

   localparam int N = CORDIC_STAGES;
   localparam logic [ANGLE_BITS-3:0] HALF_QTR = (ANGLE_BITS-2)'(1) << (ANGLE_BITS - 3);
   localparam cordic_word_type Z_TOL = cordic_word_type'(1) <<< ANGLE_SHIFT;

   logic advance;

   // CORDIC pipeline, index 0 is the folded input
   cordic_word_type x_ff [0:N][AXES];
   cordic_word_type x_in [0:N][AXES];
   cordic_word_type y_ff [0:N][AXES];
   cordic_word_type y_in [0:N][AXES];
   cordic_word_type z_ff [0:N][AXES];
   cordic_word_type z_in [0:N][AXES];
   quad_type        quad_ff [0:N][AXES];
   quad_type        quad_in [0:N][AXES];
   logic            swap_ff [0:N][AXES];
   logic            swap_in [0:N][AXES];
   logic [N:0]      cvalid_ff;

   // sine / cosine stage
   val_type sin_ff [AXES];
   val_type sin_in [AXES];
   val_type cos_ff [AXES];
   val_type cos_in [AXES];
   logic    sc_valid_ff;

   // first product stage
   val_type cz1_ff, sz1_ff, nsz1_ff, cx1_ff, sx1_ff, cy1_ff, nsy1_ff;
   val_type t10_ff, t12_ff, t20_ff, t22_ff;
   val_type t10_in, t12_in, t20_in, t22_in;
   logic    p1_valid_ff;

   // second product stage
   val_type a00_ff, a01_ff, a10_ff, b10_ff, a11_ff, b11_ff;
   val_type a20_ff, b20_ff, a21_ff, b21_ff, m02_ff, m12_ff, m22_ff;
   logic    p2_valid_ff;

   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;
   logic            rsp_valid_ff;

   logic [ANGLE_BITS-1:0] angle [AXES];

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign angle[0] = req_payload.angle_x;
   assign angle[1] = req_payload.angle_y;
   assign angle[2] = req_payload.angle_z;

   always_comb begin
      logic [ANGLE_BITS-3:0] r;
      logic                  sw;
      val_type               s0, c0, s, c;
      for (int ax = 0; ax < AXES; ax++) begin
         r  = angle[ax][ANGLE_BITS-3:0];
         sw = 1'b0;
         if (r > HALF_QTR) begin
            r  = (ANGLE_BITS-2)'(0) - r;
            sw = 1'b1;
         end
         x_in[0][ax]    = CORDIC_GAIN;
         y_in[0][ax]    = '0;
         z_in[0][ax]    = cordic_word_type'(r) <<< ANGLE_SHIFT;
         quad_in[0][ax] = quad_type'(angle[ax][ANGLE_BITS-1:ANGLE_BITS-2]);
         swap_in[0][ax] = sw;
      end
      for (int st = 1; st <= N; st++) begin
         for (int ax = 0; ax < AXES; ax++) begin
            if (!z_ff[st-1][ax][CORDIC_BITS-1]) begin
               x_in[st][ax] = x_ff[st-1][ax] - (y_ff[st-1][ax] >>> (st - 1));
               y_in[st][ax] = y_ff[st-1][ax] + (x_ff[st-1][ax] >>> (st - 1));
               z_in[st][ax] = z_ff[st-1][ax] - cordic_word_type'(ATAN_TABLE[st-1]);
            end else begin
               x_in[st][ax] = x_ff[st-1][ax] + (y_ff[st-1][ax] >>> (st - 1));
               y_in[st][ax] = y_ff[st-1][ax] - (x_ff[st-1][ax] >>> (st - 1));
               z_in[st][ax] = z_ff[st-1][ax] + cordic_word_type'(ATAN_TABLE[st-1]);
            end
            quad_in[st][ax] = quad_ff[st-1][ax];
            swap_in[st][ax] = swap_ff[st-1][ax];
         end
      end
      for (int ax = 0; ax < AXES; ax++) begin
         s0 = cordic_round(y_ff[N][ax]);
         c0 = cordic_round(x_ff[N][ax]);
         s  = swap_ff[N][ax] ? c0 : s0;
         c  = swap_ff[N][ax] ? s0 : c0;
         case (quad_ff[N][ax])
            QUAD_I: begin
               sin_in[ax] = s;
               cos_in[ax] = c;
            end
            QUAD_II: begin
               sin_in[ax] = c;
               cos_in[ax] = -s;
            end
            QUAD_III: begin
               sin_in[ax] = -s;
               cos_in[ax] = -c;
            end
            default: begin
               sin_in[ax] = -c;
               cos_in[ax] = s;
            end
         endcase
      end
   end

   always_comb begin
      t10_in = rnd_mul(sin_ff[1], -sin_ff[0]);
      t12_in = rnd_mul(cos_ff[1], -sin_ff[0]);
      t20_in = rnd_mul(sin_ff[1], cos_ff[0]);
      t22_in = rnd_mul(cos_ff[1], cos_ff[0]);
   end

   always_comb begin
      rsp_payload_in.m00 = a00_ff;
      rsp_payload_in.m01 = a01_ff;
      rsp_payload_in.m02 = m02_ff;
      rsp_payload_in.m10 = clamp_sum(a10_ff, b10_ff);
      rsp_payload_in.m11 = clamp_sum(a11_ff, b11_ff);
      rsp_payload_in.m12 = m12_ff;
      rsp_payload_in.m20 = clamp_sum(a20_ff, b20_ff);
      rsp_payload_in.m21 = clamp_sum(a21_ff, b21_ff);
      rsp_payload_in.m22 = m22_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff    <= '0;
         sc_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         cvalid_ff    <= {cvalid_ff[N-1:0], req_valid};
         sc_valid_ff  <= cvalid_ff[N];
         p1_valid_ff  <= sc_valid_ff;
         p2_valid_ff  <= p1_valid_ff;
         rsp_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         quad_ff <= quad_in;
         swap_ff <= swap_in;
         sin_ff  <= sin_in;
         cos_ff  <= cos_in;

         cz1_ff  <= cos_ff[2];
         sz1_ff  <= sin_ff[2];
         nsz1_ff <= -sin_ff[2];
         cx1_ff  <= cos_ff[0];
         sx1_ff  <= sin_ff[0];
         cy1_ff  <= cos_ff[1];
         nsy1_ff <= -sin_ff[1];
         t10_ff  <= t10_in;
         t12_ff  <= t12_in;
         t20_ff  <= t20_in;
         t22_ff  <= t22_in;

         a00_ff <= rnd_mul(cz1_ff, cy1_ff);
         a01_ff <= rnd_mul(nsz1_ff, cy1_ff);
         a10_ff <= rnd_mul(cz1_ff, t10_ff);
         b10_ff <= rnd_mul(sz1_ff, cx1_ff);
         a11_ff <= rnd_mul(nsz1_ff, t10_ff);
         b11_ff <= rnd_mul(cz1_ff, cx1_ff);
         a20_ff <= rnd_mul(cz1_ff, t20_ff);
         b20_ff <= rnd_mul(sz1_ff, sx1_ff);
         a21_ff <= rnd_mul(nsz1_ff, t20_ff);
         b21_ff <= rnd_mul(cz1_ff, sx1_ff);
         m02_ff <= nsy1_ff;
         m12_ff <= t12_ff;
         m22_ff <= t22_ff;

         rsp_payload_ff <= rsp_payload_in;
      end
   end

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(cvalid_ff) && $stable(p2_valid_ff))
      else $error("pipeline moved while output stalled");

   a_cordic_converged: assert property (@(posedge clock) disable iff (reset)
      cvalid_ff[N] |-> (z_ff[N][0] < Z_TOL) && (z_ff[N][0] > -Z_TOL))
      else $error("CORDIC residual angle too large");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.m11 <= VAL_ONE) && (rsp_payload_ff.m11 >= -VAL_ONE)
                    && (rsp_payload_ff.m20 <= VAL_ONE) && (rsp_payload_ff.m20 >= -VAL_ONE))
      else $error("matrix element out of range");

endmodule
`default_nettype wire

/* tb/tb_euler_rotation_matrix_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Euler rotation matrix unit testbench
// Drives angle triples through the block and checks each Z*Y*X matrix
// against a bit-exact predictor, with sender idling and receiver stalls.
// ---------------------------------------------------------------------------
module tb_euler_rotation_matrix_unit;
   import erm_pkg::*;

   localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
   localparam logic [63:0] Q62_ONE     = 64'h4000000000000000;
   localparam longint      ONE         = longint'(1) << FRAC_BITS;
   localparam int          WDOG_LIMIT  = 5000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   rsp_payload_type matrix_q[$];
   int              idle_pct  = 0;
   int              stall_pct = 0;
   int              errors    = 0;
   int              quiet     = 0;

   euler_rotation_matrix_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      return p[125:62];
   endfunction

   function automatic longint q62_round(input logic [63:0] v);
      logic [63:0] t;
      t = v + (64'd1 << (61 - FRAC_BITS));
      return longint'(t >> (62 - FRAC_BITS));
   endfunction

   task automatic sin_cos(input logic [ANGLE_BITS-1:0] ang, output longint sn,
                          output longint cs);
      logic [63:0]  quarter, r, x, x2, term, ssum, csum;
      logic [127:0] p;
      logic [1:0]   q;
      longint       s0, c0, s, c;
      quarter = 64'd1 << (ANGLE_BITS - 2);
      q = ang[ANGLE_BITS-1 -: 2];
      r = 64'(ang) & (quarter - 1);
      s0 = 0;
      if (r > (quarter >> 1)) r = quarter - r;
      p = r * PI_HALF_Q62;
      x = 64'(p >> (ANGLE_BITS - 2));
      x2 = mul_q62(x, x);
      ssum = x;
      term = x;
      for (int n = 1; n <= 9; n++) begin
         term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
         if (n & 1) ssum = ssum - term; else ssum = ssum + term;
      end
      csum = Q62_ONE;
      term = Q62_ONE;
      for (int n = 1; n <= 9; n++) begin
         term = mul_q62(term, x2) / 64'((2 * n - 1) * (2 * n));
         if (n & 1) csum = csum - term; else csum = csum + term;
      end
      s0 = q62_round(ssum);
      c0 = q62_round(csum);
      if ((64'(ang) & (quarter - 1)) > (quarter >> 1)) begin
         s = c0; c = s0;
      end else begin
         s = s0; c = c0;
      end
      case (q)
         2'd0: begin sn = s;  cs = c;  end
         2'd1: begin sn = c;  cs = -s; end
         2'd2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endtask

   function automatic longint rnd_prod(input longint p);
      return (p + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   typedef longint mat_type [3][3];

   function automatic mat_type mat_product(input mat_type a, input mat_type b);
      mat_type o;
      longint  acc;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += rnd_prod(a[k][j] * b[i][k]);
            o[i][j] = acc > ONE ? ONE : (acc < -ONE ? -ONE : acc);
         end
      return o;
   endfunction

   task automatic predict_matrix(input req_payload_type a, output rsp_payload_type m);
      longint  sx, cx, sy, cy, sz, cz;
      mat_type rx, ry, rz, t, o;
      sin_cos(a.angle_x, sx, cx);
      sin_cos(a.angle_y, sy, cy);
      sin_cos(a.angle_z, sz, cz);
      rx = '{'{ONE, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
      ry = '{'{cy, 0, -sy}, '{0, ONE, 0}, '{sy, 0, cy}};
      rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, ONE}};
      t = mat_product(ry, rx);
      o = mat_product(rz, t);
      m = {val_type'(o[0][0]), val_type'(o[0][1]), val_type'(o[0][2]),
           val_type'(o[1][0]), val_type'(o[1][1]), val_type'(o[1][2]),
           val_type'(o[2][0]), val_type'(o[2][1]), val_type'(o[2][2])};
   endtask

   task automatic send_angles(input req_payload_type a);
      rsp_payload_type m;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= a;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_matrix(a, m);
      matrix_q.push_back(m);
   endtask

   function automatic req_payload_type rand_angles();
      return req_payload_type'({16'($urandom), 16'($urandom), 16'($urandom)});
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (matrix_q.size() == 0) begin
            $display("%0t: unexpected transfer %h", $time, rsp_payload);
            errors++;
         end else begin
            e = matrix_q.pop_front();
            for (int f = 0; f < 9; f++)
               if (e[f*VAL_BITS +: VAL_BITS] !== rsp_payload[f*VAL_BITS +: VAL_BITS]) begin
                  $display("%0t: m%0d%0d expected %0d actual %0d", $time, (8 - f) / 3,
                           (8 - f) % 3, $signed(e[f*VAL_BITS +: VAL_BITS]),
                           $signed(rsp_payload[f*VAL_BITS +: VAL_BITS]));
                  errors++;
               end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WDOG_LIMIT) begin
         $display("FAIL euler_rotation_matrix_unit");
         $finish;
      end
   end

   task automatic test_directed();
      logic [15:0] edges [10] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                  16'h2000, 16'h2001, 16'h1FFF, 16'h0001, 16'h5555};
      idle_pct = 0; stall_pct = 0;
      foreach (edges[i]) send_angles('{edges[i], edges[i], edges[i]});
      send_angles('{16'h4000, 16'h0000, 16'h0000});
      send_angles('{16'h0000, 16'h4000, 16'h0000});
      send_angles('{16'h0000, 16'h0000, 16'h4000});
      send_angles('{16'h6000, 16'hA000, 16'hE000});
      send_angles('{16'hFFFF, 16'h0000, 16'h8000});
   endtask

   task automatic test_random(input int idle, input int stall, input int n);
      idle_pct = idle; stall_pct = stall;
      repeat (n) send_angles(rand_angles());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(0, 0, 500);
      test_random(60, 0, 500);
      test_random(0, 60, 500);
      test_random(14, 14, 500);
      test_random(0, 0, 20);
      req_valid <= 1'b0;
      while (matrix_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) $display("PASS euler_rotation_matrix_unit");
      else $display("FAIL euler_rotation_matrix_unit");
      $finish;
   end

endmodule
